// File: design/bqc_pkg.sv
// ----------------------------------------------------------------------------
// Biquad cascade package
// Widths, codes and shared types of the direct-form-II biquad cascade.
// ----------------------------------------------------------------------------
package bqc_pkg;

  // Fixed widths of the internal formats and of the item fields.
  localparam int STATE_W    = 48;
  localparam int COEF_W     = 32;
  localparam int COEF_NUM   = 4;
  localparam int COEF_IDX_W = 2;
  localparam int SEL_W      = 3;
  localparam int CNT_W      = 4;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 1;

  // Register reset values: unity gain in Q3.28 and one section in use.
  localparam logic signed [COEF_W-1:0] GAIN_RESET     = 32'sh1000_0000;
  localparam logic [CNT_W-1:0]         SECTIONS_RESET = 4'd1;

  // Item modes.
  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN     = 1'b0,
    CFG_SECTIONS = 1'b1
  } cfg_reg_t;

  // Coefficient slots of one section.
  typedef enum logic [COEF_IDX_W-1:0] {
    COEF_A1 = 2'd0,
    COEF_A2 = 2'd1,
    COEF_B1 = 2'd2,
    COEF_B2 = 2'd3
  } coef_sel_t;

  // Coefficient write into one cell.
  typedef struct packed {
    logic                      en;
    coef_sel_t                 idx;
    logic signed [COEF_W-1:0]  value;
  } coef_wr_t;

  // Sample token handed from cell to cell.
  typedef struct packed {
    logic                      valid;
    logic                      clip;
    logic signed [STATE_W-1:0] x;
  } tok_t;

endpackage

// File: design/bqc_in_if.sv
// ----------------------------------------------------------------------------
// Biquad cascade input channel
// Valid/ready channel that carries samples and coefficient writes.
// ----------------------------------------------------------------------------
interface bqc_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic signed [SAMPLE_BITS-1:0]      sample_in;
  logic                               last_in_block;
  logic [bqc_pkg::SEL_W-1:0]          section_sel;
  logic [bqc_pkg::COEF_IDX_W-1:0]     coef_sel;
  logic signed [bqc_pkg::COEF_W-1:0]  coef_value;

  modport source (
    output valid, mode, sample_in, last_in_block, section_sel, coef_sel, coef_value,
    input  ready
  );

  modport sink (
    input  valid, mode, sample_in, last_in_block, section_sel, coef_sel, coef_value,
    output ready
  );
endinterface

// File: design/bqc_out_if.sv
// ----------------------------------------------------------------------------
// Biquad cascade output channel
// Valid/ready channel that carries filtered samples and the clip flag.
// ----------------------------------------------------------------------------
interface bqc_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;

  modport source (
    output valid, sample_out, saturated,
    input  ready
  );

  modport sink (
    input  valid, sample_out, saturated,
    output ready
  );
endinterface

// File: design/biquad_cascade_df2.sv
// ----------------------------------------------------------------------------
// Biquad cascade, direct form II
// Scales each sample by a gain and runs it through a row of section cells.
// ----------------------------------------------------------------------------
// A sample transfer starts the gain product and the four products of each
// cell, all through three-stage multipliers; once all are in, the token
// crosses one cell per cycle, and the result is rounded into the output register.
// A new sample is taken only after the last result is loaded; coefficient
// writes are taken while idle. Reset clears the delays, sets gain to 1.0 and one
// section in use; coefficients are not reset and must be written before use.
// ----------------------------------------------------------------------------
module biquad_cascade_df2 #(
  parameter int MAX_SECTIONS   = 8,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bqc_pkg::CFG_W-1:0]          cfg_data,
  bqc_in_if.sink                             item,
  bqc_out_if.source                          result
);

  localparam int STATE_W    = bqc_pkg::STATE_W;
  localparam int COEF_W     = bqc_pkg::COEF_W;
  localparam int CNT_W      = bqc_pkg::CNT_W;
  localparam int STATE_FRAC = 40 - SAMPLE_BITS;
  localparam int OUT_EXT_W  = STATE_W - SAMPLE_BITS + 2;

  localparam logic signed [STATE_W:0] HALF_LSB = (STATE_W+1)'(1) << (STATE_FRAC - 1);
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PROD   = 4'b0010,
    ST_RIPPLE = 4'b0100,
    ST_FIN    = 4'b1000
  } state_t;

  state_t                    state, state_next;
  logic signed [COEF_W-1:0]  gain;
  logic [CNT_W-1:0]          section_count;
  logic                      last_flag;
  logic                      head_ok;
  logic signed [STATE_W-1:0] head_x, fin_x;
  logic                      head_clip, fin_clip;
  logic                      res_valid, res_sat;
  logic signed [SAMPLE_BITS-1:0] res_sample;

  logic                      accept, filt_accept, coef_write;
  logic                      go, chain_done, clear, out_free, load;
  logic signed [STATE_W-1:0] head_s, head_p;
  logic                      head_done, head_pclip;
  logic signed [STATE_W:0]   rsum, rq;
  logic                      out_ovf;
  logic signed [SAMPLE_BITS-1:0] out_val;

  bqc_pkg::tok_t             tok [MAX_SECTIONS+1];
  bqc_pkg::coef_wr_t         cw [MAX_SECTIONS];
  logic [MAX_SECTIONS-1:0]   cell_ready;
  logic [MAX_SECTIONS-1:0]   cell_en;
  logic [MAX_SECTIONS:0]     tok_valid;

  // Transfer decode.
  assign item.ready  = (state == ST_IDLE);
  assign accept      = item.valid && item.ready;
  assign filt_accept = accept && (item.mode == bqc_pkg::MODE_FILTER);
  assign coef_write  = accept && (item.mode == bqc_pkg::MODE_COEF);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain          <= bqc_pkg::GAIN_RESET;
      section_count <= bqc_pkg::SECTIONS_RESET;
    end else if (cfg_write) begin
      unique case (bqc_pkg::cfg_reg_t'(cfg_index))
        bqc_pkg::CFG_GAIN:     gain          <= $signed(cfg_data[COEF_W-1:0]);
        bqc_pkg::CFG_SECTIONS: section_count <= cfg_data[CNT_W-1:0];
      endcase
    end
  end

  // Input scaling: the sample in state format times the gain.
  assign head_s = STATE_W'(item.sample_in) <<< STATE_FRAC;

  bqc_mulc #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_head_mulc (
    .clk   (clk),
    .rst   (rst),
    .start (filt_accept),
    .s     (head_s),
    .c     (gain),
    .done  (head_done),
    .prod  (head_p),
    .clip  (head_pclip)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ok <= 1'b0;
    end else if (filt_accept) begin
      head_ok <= 1'b0;
    end else if (head_done) begin
      head_ok <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_done) begin
      head_x    <= head_p;
      head_clip <= head_pclip;
    end
    if (filt_accept) begin
      last_flag <= item.last_in_block;
    end
  end

  // Row of section cells; the token enters cell 0 once all products are in.
  assign go     = (state == ST_PROD) && head_ok && (&cell_ready);
  assign tok[0] = '{valid: go, clip: head_clip, x: head_x};

  for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
    assign cell_en[i] = (int'(section_count) > i);
    assign cw[i] = '{
      en:    coef_write && (int'(item.section_sel) == i),
      idx:   bqc_pkg::coef_sel_t'(item.coef_sel),
      value: item.coef_value
    };

    bqc_cell #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cw         (cw[i]),
      .start      (filt_accept),
      .prod_ready (cell_ready[i]),
      .en         (cell_en[i]),
      .clear      (clear),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

  for (genvar i = 0; i <= MAX_SECTIONS; i++) begin : g_tok_valid
    assign tok_valid[i] = tok[i].valid;
  end

  // End of the row: capture the result, and clear the delays at block end.
  assign chain_done = tok[MAX_SECTIONS].valid;
  assign clear      = (state == ST_RIPPLE) && chain_done && last_flag;

  always_ff @(posedge clk) begin
    if ((state == ST_RIPPLE) && chain_done) begin
      fin_x    <= tok[MAX_SECTIONS].x;
      fin_clip <= tok[MAX_SECTIONS].clip;
    end
  end

  // Output rounding half up to an integer and saturation to the sample width.
  assign rsum    = (STATE_W+1)'(fin_x) + HALF_LSB;
  assign rq      = rsum >>> STATE_FRAC;
  assign out_ovf = (rq[STATE_W:SAMPLE_BITS-1] != {OUT_EXT_W{rq[STATE_W]}});
  assign out_val = out_ovf ? (rq[STATE_W] ? OUT_MIN : OUT_MAX) : rq[SAMPLE_BITS-1:0];

  // Sequencer.
  assign out_free = !res_valid || result.ready;
  assign load     = (state == ST_FIN) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (filt_accept) state_next = ST_PROD;
      ST_PROD:   if (go)          state_next = ST_RIPPLE;
      ST_RIPPLE: if (chain_done)  state_next = ST_FIN;
      ST_FIN:    if (out_free)    state_next = ST_IDLE;
      default:                    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register: holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_sample <= out_val;
      res_sat    <= fin_clip | out_ovf;
    end
  end

  assign result.valid      = res_valid;
  assign result.sample_out = res_sample;
  assign result.saturated  = res_sat;

  // Checks on the sequencing of the cell row.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valid) <= 1)
    else $error("more than one token in the cell row");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (tok_valid == '0))
    else $error("token in the cell row while idle");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    filt_accept |=> (state == ST_PROD) && (cell_ready == '0) && !head_ok)
    else $error("product phase did not restart after a sample transfer");

  a_row_end: assert property (@(posedge clk) disable iff (rst)
    tok_valid[MAX_SECTIONS] |-> (state == ST_RIPPLE))
    else $error("token left the cell row outside the ripple phase");

endmodule

// File: design/bqc_mulc.sv
// ----------------------------------------------------------------------------
// Biquad cascade coefficient multiplier
// Three-stage pipelined product of a 48-bit state value and a 32-bit
// coefficient, rounded half up to the state format and saturated to 48 bits.
// ----------------------------------------------------------------------------
module bqc_mulc #(
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [bqc_pkg::STATE_W-1:0] s,
  input  logic signed [bqc_pkg::COEF_W-1:0]  c,
  output logic                               done,
  output logic signed [bqc_pkg::STATE_W-1:0] prod,
  output logic                               clip
);

  localparam int STATE_W = bqc_pkg::STATE_W;
  localparam int COEF_W  = bqc_pkg::COEF_W;
  localparam int HALF_W  = STATE_W / 2;
  localparam int LO_W    = COEF_W + HALF_W + 1;
  localparam int HI_W    = COEF_W + HALF_W;
  localparam int PROD_W  = COEF_W + STATE_W;
  localparam int EXT_W   = PROD_W - STATE_W + 1;

  localparam logic signed [PROD_W-1:0]  ROUND  = PROD_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};

  logic                     v1, v2;
  logic signed [LO_W-1:0]   lo_prod, lo_r, lo2;
  logic signed [HALF_W-1:0] hi_s;
  logic signed [COEF_W-1:0] c1;
  logic signed [HI_W-1:0]   hi_r;
  logic signed [PROD_W-1:0] sum, q;
  logic                     ovf;

  // Stage 1: coefficient times the unsigned low half of the value.
  assign lo_prod = c * $signed({1'b0, s[HALF_W-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_prod;
    hi_s <= s[STATE_W-1:HALF_W];
    c1   <= c;
  end

  // Stage 2: coefficient times the signed high half.
  always_ff @(posedge clk) begin
    hi_r <= c1 * hi_s;
    lo2  <= lo_r;
  end

  // Stage 3: recombine, round half up, drop the fraction bits and saturate.
  assign sum = (PROD_W'(hi_r) <<< HALF_W) + PROD_W'(lo2) + ROUND;
  assign q   = sum >>> COEF_FRAC_BITS;
  assign ovf = (q[PROD_W-1:STATE_W-1] != {EXT_W{q[PROD_W-1]}});

  always_ff @(posedge clk) begin
    if (ovf) begin
      prod <= q[PROD_W-1] ? ST_MIN : ST_MAX;
    end else begin
      prod <= q[STATE_W-1:0];
    end
    clip <= ovf;
  end

endmodule

// File: design/bqc_cell.sv
// ----------------------------------------------------------------------------
// Biquad cascade section cell
// One direct-form-II section: its coefficients, its delay pair, a multiplier
// that forms the four feedback and feedforward products, and the adders that
// turn the passing token into the next section's input.
// ----------------------------------------------------------------------------
module bqc_cell #(
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic              clk,
  input  logic              rst,
  input  bqc_pkg::coef_wr_t cw,
  input  logic              start,
  output logic              prod_ready,
  input  logic              en,
  input  logic              clear,
  input  bqc_pkg::tok_t     tok_in,
  output bqc_pkg::tok_t     tok_out
);

  localparam int STATE_W    = bqc_pkg::STATE_W;
  localparam int COEF_W     = bqc_pkg::COEF_W;
  localparam int COEF_NUM   = bqc_pkg::COEF_NUM;
  localparam int COEF_IDX_W = bqc_pkg::COEF_IDX_W;
  localparam int SUM_W      = STATE_W + 2;

  localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};

  logic signed [COEF_W-1:0]  coef [COEF_NUM];
  logic signed [STATE_W-1:0] d1, d2;
  logic                      issue_busy;
  logic [COEF_IDX_W-1:0]     issue_idx;
  logic [COEF_IDX_W-1:0]     res_idx;
  logic signed [STATE_W:0]   fb, ff;
  logic                      pclip;

  logic signed [STATE_W-1:0] mul_s, mul_p;
  logic signed [COEF_W-1:0]  mul_c;
  logic                      mul_done, mul_clip;

  logic signed [SUM_W-1:0]   w_full, y_full;
  logic signed [STATE_W-1:0] w, y;
  logic                      w_ovf, y_ovf;

  logic                      tok_valid;
  logic                      tok_clip;
  logic signed [STATE_W-1:0] tok_x;

  // Coefficient storage, written by mode-1 transfers.
  always_ff @(posedge clk) begin
    if (cw.en) begin
      coef[cw.idx] <= cw.value;
    end
  end

  // Issue the four products, one a cycle: a1 and b1 use the first delay,
  // a2 and b2 the second, so the low index bit picks the delay.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_busy <= 1'b0;
      issue_idx  <= '0;
    end else if (start) begin
      issue_busy <= 1'b1;
      issue_idx  <= '0;
    end else if (issue_busy) begin
      issue_idx <= issue_idx + COEF_IDX_W'(1);
      if (issue_idx == bqc_pkg::COEF_B2) begin
        issue_busy <= 1'b0;
      end
    end
  end

  assign mul_s = issue_idx[0] ? d2 : d1;
  assign mul_c = coef[issue_idx];

  bqc_mulc #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mulc (
    .clk   (clk),
    .rst   (rst),
    .start (issue_busy),
    .s     (mul_s),
    .c     (mul_c),
    .done  (mul_done),
    .prod  (mul_p),
    .clip  (mul_clip)
  );

  // Count returning products; the sums are ready after the fourth.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_idx    <= '0;
      prod_ready <= 1'b0;
    end else if (start) begin
      res_idx    <= '0;
      prod_ready <= 1'b0;
    end else if (mul_done) begin
      res_idx <= res_idx + COEF_IDX_W'(1);
      if (res_idx == bqc_pkg::COEF_B2) begin
        prod_ready <= 1'b1;
      end
    end
  end

  // Feedback sum a1*d1 + a2*d2 and feedforward sum b1*d1 + b2*d2.
  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (bqc_pkg::coef_sel_t'(res_idx))
        bqc_pkg::COEF_A1: begin
          fb    <= (STATE_W+1)'(mul_p);
          pclip <= mul_clip;
        end
        bqc_pkg::COEF_A2: begin
          fb    <= fb + (STATE_W+1)'(mul_p);
          pclip <= pclip | mul_clip;
        end
        bqc_pkg::COEF_B1: begin
          ff    <= (STATE_W+1)'(mul_p);
          pclip <= pclip | mul_clip;
        end
        bqc_pkg::COEF_B2: begin
          ff    <= ff + (STATE_W+1)'(mul_p);
          pclip <= pclip | mul_clip;
        end
      endcase
    end
  end

  // Section arithmetic on the passing token, each step saturated to 48 bits.
  assign w_full = SUM_W'(tok_in.x) - SUM_W'(fb);
  assign w_ovf  = (w_full[SUM_W-1:STATE_W-1] != {3{w_full[SUM_W-1]}});
  assign w      = w_ovf ? (w_full[SUM_W-1] ? ST_MIN : ST_MAX) : w_full[STATE_W-1:0];

  assign y_full = SUM_W'(w) + SUM_W'(ff);
  assign y_ovf  = (y_full[SUM_W-1:STATE_W-1] != {3{y_full[SUM_W-1]}});
  assign y      = y_ovf ? (y_full[SUM_W-1] ? ST_MIN : ST_MAX) : y_full[STATE_W-1:0];

  // Delay pair: shifts when a token passes an active section.
  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0;
      d2 <= '0;
    end else if (clear) begin
      d1 <= '0;
      d2 <= '0;
    end else if (tok_in.valid && en) begin
      d2 <= d1;
      d1 <= w;
    end
  end

  // Hand the token on; an unused section passes it unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      if (en) begin
        tok_x    <= y;
        tok_clip <= tok_in.clip | pclip | w_ovf | y_ovf;
      end else begin
        tok_x    <= tok_in.x;
        tok_clip <= tok_in.clip;
      end
    end
  end

  assign tok_out = '{valid: tok_valid, clip: tok_clip, x: tok_x};

endmodule
